@@ src/rc4_pkg.sv @@
// Shared types and constants of the RC4 stream cipher.
// Used by rc4_sbox and rc4_stream_cipher; depends on nothing.
`default_nettype none

package rc4_pkg;

    localparam int BYTE_W        = 8;
    localparam int SBOX_DEPTH    = 256;
    localparam int ADDR_W        = 8;
    localparam int MAX_KEY_BYTES = 16;
    localparam int KEY_LEN_W     = 5;
    localparam int KIDX_W        = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 2'd2;

    // one read and one write port request to the permutation memory
    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
    } t_mem_req;

endpackage

`default_nettype wire

@@ src/rc4_sbox.sv @@
// 256 x 8 permutation memory: one write and one registered read per cycle.
// Depends on rc4_pkg for widths and the request struct.
`default_nettype none

module rc4_sbox (
    input  wire logic                       i_clk,
    input  wire rc4_pkg::t_mem_req          i_req,
    output logic [rc4_pkg::BYTE_W-1:0]      o_rdata
);

    logic [rc4_pkg::BYTE_W-1:0] r_mem [rc4_pkg::SBOX_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // read data holds while no read is requested
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/rc4_stream_cipher.sv @@
// Top level of the RC4 stream cipher: sequencer, key registers, output register.
// Depends on rc4_pkg and rc4_sbox.
//
// Usage:
//   Input channel: i_valid / o_stall with i_data_in and i_start_message.
//   Output channel: o_valid / i_stall with o_data_out, one result per input.
//   Config: i_cfg_we, i_cfg_idx, i_cfg_data; index 0 key bytes 0..7, index 1
//   key bytes 8..15, index 2 key length (0 acts as 1, above 16 acts as 16).
//   Write config only while the block is idle.
// Timing:
//   An item is taken only in the idle state; o_stall is high while it works.
//   A plain byte runs G_RD_I, G_RD_J, G_WR_I, G_WR_J, G_RD_T and G_OUT,
//   which registers o_valid, then returns to idle: each keystream byte needs
//   five sequential accesses to the single-port-read permutation memory.
//   A message start (or the first item after reset) adds the key schedule:
//   a fill of all 256 entries, then 256 swap steps of two reads and two writes.
// Reset and backpressure:
//   Reset clears the indexes and the schedule flag, so the first item always
//   runs the key schedule. The result sits in an output register; while the
//   receiver stalls, the block still accepts the next item and finishes it
//   up to the output register, then waits for it to drain.
`default_nettype none

module rc4_stream_cipher (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [rc4_pkg::BYTE_W-1:0]        i_data_in,
    input  wire logic                              i_start_message,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [rc4_pkg::BYTE_W-1:0]             o_data_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [rc4_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [rc4_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_FILL     = 4'd1;
    localparam logic [3:0] ST_KS_RD_N  = 4'd2;
    localparam logic [3:0] ST_KS_RD_J  = 4'd3;
    localparam logic [3:0] ST_KS_WR_N  = 4'd4;
    localparam logic [3:0] ST_KS_WR_J  = 4'd5;
    localparam logic [3:0] ST_G_RD_I   = 4'd6;
    localparam logic [3:0] ST_G_RD_J   = 4'd7;
    localparam logic [3:0] ST_G_WR_I   = 4'd8;
    localparam logic [3:0] ST_G_WR_J   = 4'd9;
    localparam logic [3:0] ST_G_RD_T   = 4'd10;
    localparam logic [3:0] ST_G_OUT    = 4'd11;

    localparam logic [rc4_pkg::ADDR_W-1:0] LAST_ADDR =
        rc4_pkg::ADDR_W'(rc4_pkg::SBOX_DEPTH - 1);
    localparam logic [rc4_pkg::KEY_LEN_W-1:0] MAX_LEN =
        rc4_pkg::KEY_LEN_W'(rc4_pkg::MAX_KEY_BYTES);

    // control state
    logic [3:0]                      r_state, n_state;
    logic                            r_done, n_done;
    logic                            r_out_valid, n_out_valid;
    logic [rc4_pkg::CFG_DATA_W-1:0]  r_key_lo, r_key_hi;
    logic [rc4_pkg::KEY_LEN_W-1:0]   r_key_len;
    logic [rc4_pkg::ADDR_W-1:0]      r_i, n_i;
    logic [rc4_pkg::ADDR_W-1:0]      r_j, n_j;
    logic [rc4_pkg::ADDR_W-1:0]      r_n, n_n;
    logic [rc4_pkg::KIDX_W-1:0]      r_kidx, n_kidx;

    // payload
    logic [rc4_pkg::BYTE_W-1:0]      r_data, n_data;
    logic [rc4_pkg::BYTE_W-1:0]      r_si, n_si;
    logic [rc4_pkg::ADDR_W-1:0]      r_t, n_t;
    logic [rc4_pkg::BYTE_W-1:0]      r_out_data, n_out_data;

    rc4_pkg::t_mem_req               w_req;
    logic [rc4_pkg::BYTE_W-1:0]      w_rdata;
    logic [2*rc4_pkg::CFG_DATA_W-1:0] w_key;
    logic [rc4_pkg::BYTE_W-1:0]      w_key_byte;
    logic [rc4_pkg::KEY_LEN_W-1:0]   w_eff_len;
    logic                            w_kidx_last;
    logic [rc4_pkg::ADDR_W-1:0]      w_sum;

    rc4_sbox u_sbox (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    assign o_stall    = (r_state != ST_IDLE);
    assign o_valid    = r_out_valid;
    assign o_data_out = r_out_data;

    assign w_key      = {r_key_hi, r_key_lo};
    assign w_key_byte = w_key[{r_kidx, 3'b000} +: rc4_pkg::BYTE_W];

    always_comb begin
        priority if (r_key_len == '0) begin
            w_eff_len = rc4_pkg::KEY_LEN_W'(1);
        end else if (r_key_len > MAX_LEN) begin
            w_eff_len = MAX_LEN;
        end else begin
            w_eff_len = r_key_len;
        end
    end

    assign w_kidx_last = ({1'b0, r_kidx} == (w_eff_len - rc4_pkg::KEY_LEN_W'(1)));

    // the shared byte adder: j update in schedule and generation, t in generation
    always_comb begin
        unique case (r_state)
            ST_KS_RD_J: w_sum = r_j + w_rdata + w_key_byte;
            ST_G_RD_J:  w_sum = r_j + w_rdata;
            default:    w_sum = r_si + w_rdata;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_done      = r_done;
        n_i         = r_i;
        n_j         = r_j;
        n_n         = r_n;
        n_kidx      = r_kidx;
        n_data      = r_data;
        n_si        = r_si;
        n_t         = r_t;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && i_stall;
        w_req       = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_data  = i_data_in;
                    n_n     = '0;
                    if (i_start_message || !r_done) begin
                        n_state = ST_FILL;
                    end else begin
                        n_state = ST_G_RD_I;
                    end
                end
            end
            ST_FILL: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_n;
                w_req.wdata = r_n;
                n_n         = r_n + 1'b1;
                if (r_n == LAST_ADDR) begin
                    n_j     = '0;
                    n_kidx  = '0;
                    n_state = ST_KS_RD_N;
                end
            end
            ST_KS_RD_N: begin
                w_req.re    = 1'b1;
                w_req.raddr = r_n;
                n_state     = ST_KS_RD_J;
            end
            ST_KS_RD_J: begin
                n_si        = w_rdata;
                n_j         = w_sum;
                w_req.re    = 1'b1;
                w_req.raddr = w_sum;
                n_state     = ST_KS_WR_N;
            end
            ST_KS_WR_N: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_n;
                w_req.wdata = w_rdata;
                n_state     = ST_KS_WR_J;
            end
            ST_KS_WR_J: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_j;
                w_req.wdata = r_si;
                n_n         = r_n + 1'b1;
                n_kidx      = w_kidx_last ? '0 : r_kidx + 1'b1;
                if (r_n == LAST_ADDR) begin
                    // generation restarts both indexes at zero
                    n_i     = '0;
                    n_j     = '0;
                    n_done  = 1'b1;
                    n_state = ST_G_RD_I;
                end else begin
                    n_state = ST_KS_RD_N;
                end
            end
            ST_G_RD_I: begin
                n_i         = r_i + 1'b1;
                w_req.re    = 1'b1;
                w_req.raddr = r_i + 1'b1;
                n_state     = ST_G_RD_J;
            end
            ST_G_RD_J: begin
                n_si        = w_rdata;
                n_j         = w_sum;
                w_req.re    = 1'b1;
                w_req.raddr = w_sum;
                n_state     = ST_G_WR_I;
            end
            ST_G_WR_I: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_i;
                w_req.wdata = w_rdata;
                n_t         = w_sum;
                n_state     = ST_G_WR_J;
            end
            ST_G_WR_J: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_j;
                w_req.wdata = r_si;
                n_state     = ST_G_RD_T;
            end
            ST_G_RD_T: begin
                w_req.re    = 1'b1;
                w_req.raddr = r_t;
                n_state     = ST_G_OUT;
            end
            ST_G_OUT: begin
                // wait here while the previous result is still held
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_data ^ w_rdata;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_n         <= '0;
            r_kidx      <= '0;
        end else begin
            r_state     <= n_state;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
            r_i         <= n_i;
            r_j         <= n_j;
            r_n         <= n_n;
            r_kidx      <= n_kidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data     <= n_data;
        r_si       <= n_si;
        r_t        <= n_t;
        r_out_data <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo  <= '0;
            r_key_hi  <= '0;
            r_key_len <= rc4_pkg::KEY_LEN_W'(8);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rc4_pkg::REG_KEY_LOW:  r_key_lo  <= i_cfg_data;
                rc4_pkg::REG_KEY_HIGH: r_key_hi  <= i_cfg_data;
                rc4_pkg::REG_KEY_LEN:  r_key_len <= i_cfg_data[rc4_pkg::KEY_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req.re && w_req.we) |-> (w_req.raddr != w_req.waddr))
        else $error("permutation read and write hit one address");

    a_gen_after_sched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_G_RD_I) |-> r_done)
        else $error("keystream generation before key schedule");

    a_start_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_valid && i_start_message) |=> (r_state == ST_FILL))
        else $error("message start did not rerun the key schedule");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_G_OUT))
        else $error("result raised outside the output step");

    a_start_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_KS_WR_J && r_n == LAST_ADDR) |=> (r_done && r_i == '0 && r_j == '0))
        else $error("schedule end did not reset indexes");
`endif

endmodule

`default_nettype wire
